### hw/rtl/wact_pkg.sv
// Shared types and constants for the windup/active/cooldown timer.
// Holds the item structs, phase and action codes, and register indexes.
// No dependencies.
package wact_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [1:0] PH_READY  = 2'd0;
  localparam logic [1:0] PH_WIND   = 2'd1;
  localparam logic [1:0] PH_ACTIVE = 2'd2;
  localparam logic [1:0] PH_COOL   = 2'd3;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_RESET  = 2'd3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WIND_UP_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_LENGTH    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COOL_DOWN_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MANUAL_HOLD      = 2'd3;

  typedef struct packed {
    logic [1:0]             action;
    logic [FIELD_WIDTH-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             phase;
    logic [FIELD_WIDTH-1:0] time_left;
  } out_item_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] wind_up_length;
    logic [FIELD_WIDTH-1:0] active_length;
    logic [FIELD_WIDTH-1:0] cool_down_length;
    logic                   manual_hold;
  } cfg_t;

endpackage

### hw/rtl/wact_cfg.sv
// Configuration register file for the timer: three phase lengths and hold.
// Depends on wact_pkg.
module wact_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wact_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wact_pkg::FIELD_WIDTH-1:0]      cfg_data,
  output wact_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        wact_pkg::REG_WIND_UP_LENGTH:   cfg.wind_up_length   <= cfg_data;
        wact_pkg::REG_ACTIVE_LENGTH:    cfg.active_length    <= cfg_data;
        wact_pkg::REG_COOL_DOWN_LENGTH: cfg.cool_down_length <= cfg_data;
        wact_pkg::REG_MANUAL_HOLD:      cfg.manual_hold      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/wact_step.sv
// Next-state logic of the timer for one item: command decode, saturating
// countdown and phase entry with zero-length skipping. Depends on wact_pkg.
module wact_step #(
  parameter int TIME_WIDTH = wact_pkg::TIME_WIDTH_DEFAULT
) (
  input  wact_pkg::cfg_t          cfg,
  input  logic [1:0]              cur_phase,
  input  logic [TIME_WIDTH-1:0]   cur_rem,
  input  wact_pkg::in_item_t      item,
  output logic [1:0]              next_phase,
  output logic [TIME_WIDTH-1:0]   next_rem
);

  // Fields are widened to 64 bits and then cut to the time width, which
  // covers time widths up to 64 bits, narrower or wider than the fields.
  logic [63:0]           wind_wide, active_wide, cool_wide, dt_wide;
  logic [TIME_WIDTH-1:0] wind_len, active_len, cool_len, dt;
  logic                  wind_nz, active_nz, cool_stays;
  logic [TIME_WIDTH-1:0] rem_sub;
  logic                  do_enter;
  logic [1:0]            target;
  logic                  reach_active, reach_cool;

  assign wind_wide   = 64'(cfg.wind_up_length);
  assign active_wide = 64'(cfg.active_length);
  assign cool_wide   = 64'(cfg.cool_down_length);
  assign dt_wide     = 64'(item.elapsed);
  assign wind_len    = wind_wide[TIME_WIDTH-1:0];
  assign active_len  = active_wide[TIME_WIDTH-1:0];
  assign cool_len    = cool_wide[TIME_WIDTH-1:0];
  assign dt          = dt_wide[TIME_WIDTH-1:0];

  assign wind_nz    = (wind_len != '0);
  assign active_nz  = (active_len != '0);
  assign cool_stays = (cool_len != '0) || cfg.manual_hold;

  assign rem_sub = (cur_rem > dt) ? (cur_rem - dt) : '0;

  // Decide whether a phase is entered and which one is aimed at.
  always_comb begin
    do_enter = 1'b0;
    target   = wact_pkg::PH_READY;
    case (item.action)
      wact_pkg::ACT_START: begin
        do_enter = (cur_phase == wact_pkg::PH_READY);
        target   = wact_pkg::PH_WIND;
      end
      wact_pkg::ACT_CANCEL: begin
        do_enter = (cur_phase == wact_pkg::PH_WIND);
      end
      wact_pkg::ACT_RESET: begin
        do_enter = (cur_phase == wact_pkg::PH_COOL);
      end
      default: begin
        if (cur_phase != wact_pkg::PH_READY && rem_sub == '0) begin
          case (cur_phase)
            wact_pkg::PH_WIND: begin
              do_enter = 1'b1;
              target   = wact_pkg::PH_ACTIVE;
            end
            wact_pkg::PH_ACTIVE: begin
              do_enter = 1'b1;
              target   = wact_pkg::PH_COOL;
            end
            default: begin
              do_enter = !cfg.manual_hold;
            end
          endcase
        end
      end
    endcase
  end

  // Zero-length phases pass straight on to the next one.
  assign reach_active = (target == wact_pkg::PH_ACTIVE) ||
                        ((target == wact_pkg::PH_WIND) && !wind_nz);
  assign reach_cool   = (target == wact_pkg::PH_COOL) || (reach_active && !active_nz);

  always_comb begin
    next_phase = cur_phase;
    next_rem   = cur_rem;
    if (item.action == wact_pkg::ACT_TICK && cur_phase != wact_pkg::PH_READY) begin
      next_rem = rem_sub;
    end
    if (do_enter) begin
      if (target == wact_pkg::PH_WIND && wind_nz) begin
        next_phase = wact_pkg::PH_WIND;
        next_rem   = wind_len;
      end else if (reach_active && active_nz) begin
        next_phase = wact_pkg::PH_ACTIVE;
        next_rem   = active_len;
      end else if (reach_cool && cool_stays) begin
        next_phase = wact_pkg::PH_COOL;
        next_rem   = cool_len;
      end else begin
        next_phase = wact_pkg::PH_READY;
        next_rem   = '0;
      end
    end
  end

endmodule

### hw/rtl/windup_active_cooldown_timer_core.sv
// Top level of the four-phase action timer (ready, wind-up, active, cooldown).
// Depends on wact_pkg, wact_cfg and wact_step.
//
// Usage: each input item carries an action (tick, start, cancel, reset) and
// an elapsed amount used only by ticks. Every accepted item yields exactly one
// result item holding the phase and the time left after that item.
// Both channels use valid/stall: an item moves on a rising edge where valid
// is high and stall is low. The configuration port is a plain write port
// (cfg_write, cfg_index, cfg_data); the user must write it only while the block
// is idle, which the block itself does not enforce.
//
// An accepted item waits in the input register while the next-state logic runs,
// then the result register loads. While the receiver does not stall, the block
// takes one item every cycle; the limit is the single compare, subtract and
// phase select between the two registers. Timer state and result register load
// at the same edge, so the next item always sees the state this one leaves.
//
// When the receiver stalls, the result register holds its item; the input
// register still takes one more item and then in_stall rises until the result
// moves on. Synchronous reset empties both registers, clears all
// configuration registers and puts the timer in ready with zero time left.
module windup_active_cooldown_timer_core #(
  parameter int TIME_WIDTH = wact_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  wact_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output wact_pkg::out_item_t                   out_item,
  input  logic                                  cfg_write,
  input  logic [wact_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wact_pkg::FIELD_WIDTH-1:0]      cfg_data
);

  wact_pkg::cfg_t        cfg;

  // Input register.
  logic                  hold_valid;
  wact_pkg::in_item_t    hold_item;

  // Timer state.
  logic [1:0]            cur_phase;
  logic [TIME_WIDTH-1:0] cur_rem;
  logic [1:0]            cur_phase_next;
  logic [TIME_WIDTH-1:0] cur_rem_next;
  logic [63:0]           rem_wide;

  logic                  advance;

  wact_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wact_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .cur_phase  (cur_phase),
    .cur_rem    (cur_rem),
    .item       (hold_item),
    .next_phase (cur_phase_next),
    .next_rem   (cur_rem_next)
  );

  // The held item moves into the result register when that register is
  // empty or its item is being taken in this cycle.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  // The remaining time is reported in the 32-bit field; ready shows zero,
  // which the state already holds there.
  assign rem_wide = 64'(cur_rem_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase <= wact_pkg::PH_READY;
      cur_rem   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur_phase <= cur_phase_next;
        cur_rem   <= cur_rem_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_item.phase     <= cur_phase_next;
      out_item.time_left <= (cur_phase_next == wact_pkg::PH_READY) ?
                            '0 : rem_wide[wact_pkg::FIELD_WIDTH-1:0];
    end
  end

endmodule

### verif/tb_windup_active_cooldown_timer_core.sv
// Self-checking testbench for windup_active_cooldown_timer_core.
// Uses the types and codes of wact_pkg and keeps its own model of the timer
// to predict the phase and time left that each item must produce.
module tb_windup_active_cooldown_timer_core;

  timeunit 1ns;
  timeprecision 1ps;

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  wact_pkg::in_item_t                   in_item;
  logic                                 out_valid;
  logic                                 out_stall;
  wact_pkg::out_item_t                  out_item;
  logic                                 cfg_write;
  logic [wact_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [wact_pkg::FIELD_WIDTH-1:0]     cfg_data;

  // Shadow of the configuration registers and of the timer state.
  logic [wact_pkg::FIELD_WIDTH-1:0] wind_len = '0;
  logic [wact_pkg::FIELD_WIDTH-1:0] active_len = '0;
  logic [wact_pkg::FIELD_WIDTH-1:0] cool_len = '0;
  logic                             hold_mode = 1'b0;
  logic [1:0]                       tmr_phase = wact_pkg::PH_READY;
  logic [wact_pkg::FIELD_WIDTH-1:0] tmr_left = '0;

  // Phase and time left that each accepted item must produce, oldest first.
  wact_pkg::out_item_t pending_readouts[$];
  int                  mismatch_count = 0;

  // Idle rates in percent, and the long receiver hold-off.
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_on = 1'b0;

  windup_active_cooldown_timer_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Enter a phase and pass over phases of zero length. Cool-down is kept even
  // at zero length when manual hold is on. At most one full loop is needed.
  function automatic void enter_phase(input logic [1:0] target);
    logic [1:0] t;
    bit         settled;
    t = target;
    settled = 1'b0;
    for (int i = 0; i < 4 && !settled; i++) begin
      case (t)
        wact_pkg::PH_WIND: begin
          if (wind_len != 0) begin
            tmr_phase = wact_pkg::PH_WIND;
            tmr_left = wind_len;
            settled = 1'b1;
          end else begin
            t = wact_pkg::PH_ACTIVE;
          end
        end
        wact_pkg::PH_ACTIVE: begin
          if (active_len != 0) begin
            tmr_phase = wact_pkg::PH_ACTIVE;
            tmr_left = active_len;
            settled = 1'b1;
          end else begin
            t = wact_pkg::PH_COOL;
          end
        end
        wact_pkg::PH_COOL: begin
          if (cool_len != 0 || hold_mode) begin
            tmr_phase = wact_pkg::PH_COOL;
            tmr_left = cool_len;
            settled = 1'b1;
          end else begin
            t = wact_pkg::PH_READY;
          end
        end
        default: begin
          tmr_phase = wact_pkg::PH_READY;
          tmr_left = '0;
          settled = 1'b1;
        end
      endcase
    end
  endfunction

  // Apply one item to the shadow timer and return the readout it yields.
  function automatic wact_pkg::out_item_t advance_timer(input wact_pkg::in_item_t it);
    logic [1:0]          ph;
    wact_pkg::out_item_t r;
    ph = tmr_phase;
    case (it.action)
      wact_pkg::ACT_START:  if (ph == wact_pkg::PH_READY) enter_phase(wact_pkg::PH_WIND);
      wact_pkg::ACT_CANCEL: if (ph == wact_pkg::PH_WIND) enter_phase(wact_pkg::PH_READY);
      wact_pkg::ACT_RESET:  if (ph == wact_pkg::PH_COOL) enter_phase(wact_pkg::PH_READY);
      default: begin
        // A tick: saturating countdown; leftover elapsed time is dropped.
        if (ph != wact_pkg::PH_READY) begin
          tmr_left = (tmr_left > it.elapsed) ? tmr_left - it.elapsed : '0;
          if (tmr_left == 0) begin
            if (ph == wact_pkg::PH_WIND) enter_phase(wact_pkg::PH_ACTIVE);
            else if (ph == wact_pkg::PH_ACTIVE) enter_phase(wact_pkg::PH_COOL);
            else if (!hold_mode) enter_phase(wact_pkg::PH_READY);
          end
        end
      end
    endcase
    r.phase = tmr_phase;
    r.time_left = (tmr_phase == wact_pkg::PH_READY) ? '0 : tmr_left;
    return r;
  endfunction

  // The receiver: a long hold-off when asked for, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_on) out_stall <= 1'b1;
    else out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Each result that moves is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: result with nothing expected: phase %0d time_left %0d",
                 $time, out_item.phase, out_item.time_left);
        mismatch_count++;
      end else begin
        wact_pkg::out_item_t want;
        want = pending_readouts.pop_front();
        if (out_item.phase !== want.phase) begin
          $display("%0t: phase mismatch: expected %0d, actual %0d",
                   $time, want.phase, out_item.phase);
          mismatch_count++;
        end
        if (out_item.time_left !== want.time_left) begin
          $display("%0t: time_left mismatch: expected %0d, actual %0d",
                   $time, want.time_left, out_item.time_left);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one item, idling first at the current rate, and wait until the
  // block takes it. Valid stays high on return so back-to-back items do not
  // lower and raise it within one step.
  task automatic send_item(input logic [1:0] action,
                           input logic [wact_pkg::FIELD_WIDTH-1:0] elapsed);
    wact_pkg::in_item_t it;
    it.action = action;
    it.elapsed = elapsed;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readouts.push_back(advance_timer(it));
  endtask

  // Stop sending and wait for every expected result, then let the two-stage
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers while the block is idle.
  task automatic set_config(input logic [wact_pkg::FIELD_WIDTH-1:0] wind,
                            input logic [wact_pkg::FIELD_WIDTH-1:0] active,
                            input logic [wact_pkg::FIELD_WIDTH-1:0] cool,
                            input logic hold);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= wact_pkg::REG_WIND_UP_LENGTH;
    cfg_data <= wind;
    @(posedge clk);
    cfg_index <= wact_pkg::REG_ACTIVE_LENGTH;
    cfg_data <= active;
    @(posedge clk);
    cfg_index <= wact_pkg::REG_COOL_DOWN_LENGTH;
    cfg_data <= cool;
    @(posedge clk);
    cfg_index <= wact_pkg::REG_MANUAL_HOLD;
    cfg_data <= {{(wact_pkg::FIELD_WIDTH-1){1'b0}}, hold};
    @(posedge clk);
    cfg_write <= 1'b0;
    wind_len = wind;
    active_len = active;
    cool_len = cool;
    hold_mode = hold;
    @(posedge clk);
  endtask

  function automatic logic [wact_pkg::FIELD_WIDTH-1:0] rand_length();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 18) return $urandom;
    if (r < 22) return '1;
    return $urandom_range(1, 24);
  endfunction

  function automatic logic [wact_pkg::FIELD_WIDTH-1:0] rand_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '1;
    if (r < 12) return $urandom;
    return $urandom_range(0, 10);
  endfunction

  // Mostly the action that moves the timer on from its current phase, with
  // some stray commands mixed in.
  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 2'($urandom_range(3, 0));
    case (tmr_phase)
      wact_pkg::PH_READY: return (r < 90) ? wact_pkg::ACT_START : wact_pkg::ACT_TICK;
      wact_pkg::PH_WIND:  return (r < 25) ? wact_pkg::ACT_CANCEL : wact_pkg::ACT_TICK;
      wact_pkg::PH_COOL:
        return (r < (hold_mode ? 40 : 22)) ? wact_pkg::ACT_RESET : wact_pkg::ACT_TICK;
      default:  return wact_pkg::ACT_TICK;
    endcase
  endfunction

  // Each action in ready, stray commands later on, overshooting ticks, all-zero
  // lengths, zero cool-down under hold and the largest lengths and elapsed amounts.
  task automatic test_directed();
    set_config(3, 2, 4, 1'b0);
    send_item(wact_pkg::ACT_TICK, 0);
    send_item(wact_pkg::ACT_RESET, 0);
    send_item(wact_pkg::ACT_CANCEL, 0);
    send_item(wact_pkg::ACT_START, 0);
    send_item(wact_pkg::ACT_START, 0);
    send_item(wact_pkg::ACT_TICK, 1);
    send_item(wact_pkg::ACT_CANCEL, 0);
    send_item(wact_pkg::ACT_START, '1);
    send_item(wact_pkg::ACT_TICK, 0);
    send_item(wact_pkg::ACT_TICK, '1);
    send_item(wact_pkg::ACT_RESET, 0);
    send_item(wact_pkg::ACT_TICK, 7);
    send_item(wact_pkg::ACT_CANCEL, 0);
    send_item(wact_pkg::ACT_TICK, 4);

    // Without hold, zero lengths take a start straight back to ready.
    set_config(0, 0, 0, 1'b0);
    send_item(wact_pkg::ACT_START, 0);

    // Zero cool-down under hold parks the timer until a reset.
    set_config(0, 0, 0, 1'b1);
    send_item(wact_pkg::ACT_START, 0);
    send_item(wact_pkg::ACT_TICK, 5);
    send_item(wact_pkg::ACT_RESET, 0);

    set_config('1, '1, '1, 1'b1);
    send_item(wact_pkg::ACT_START, 0);
    send_item(wact_pkg::ACT_TICK, 32'hFFFF_FFFE);
    send_item(wact_pkg::ACT_TICK, 1);
    send_item(wact_pkg::ACT_TICK, '1);
    send_item(wact_pkg::ACT_TICK, '1);
    send_item(wact_pkg::ACT_TICK, 3);
    send_item(wact_pkg::ACT_RESET, 0);
  endtask

  // Random action sequences under random settings, through each idle mix.
  task automatic test_random();
    int idle_mix[4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{17, 17}};
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        set_config(rand_length(), rand_length(), rand_length(), 1'($urandom_range(1)));
        send_idle_pct = idle_mix[m][0];
        stall_pct = idle_mix[m][1];
        for (int n = 0; n < 150; n++) send_item(rand_action(), rand_elapsed());
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the block fills and stalls its input; then the sender
  // pauses until everything has come out.
  task automatic test_backpressure();
    set_config(5, 6, 4, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
      for (int n = 0; n < 40; n++) send_item(rand_action(), rand_elapsed());
    join
    drain();
    for (int n = 0; n < 30; n++) send_item(rand_action(), rand_elapsed());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_readouts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
